/* hdl/rvsd_pkg.sv */
// Shared widths, state codes and limits for the running variance unit.
`default_nettype none

package rvsd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;

  localparam int MEAN_W = 32;
  localparam int SUM_W  = 64;
  localparam int VAR_W  = 48;
  localparam int ROOT_W = VAR_W / 2;
  localparam int OUT_COUNT_W = 16;
  localparam int FRAC_W = 16;

  // sample in Q.16, and the difference against the mean with one guard bit
  localparam int X_W = SAMPLE_BITS + FRAC_W;
  localparam int D_W = ((X_W > MEAN_W) ? X_W : MEAN_W) + 1;

  // shared compare/subtract width: divider remainder or root remainder
  localparam int SUB_W = ((COUNT_BITS + 1) > (ROOT_W + 2)) ? (COUNT_BITS + 1) : (ROOT_W + 2);
  localparam int ITER_W = $clog2(SUM_W + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_DIFF = 11'b00000000010,
    S_MDIV = 11'b00000000100,
    S_MEAN = 11'b00000001000,
    S_ERR  = 11'b00000010000,
    S_MUL  = 11'b00000100000,
    S_ACC  = 11'b00001000000,
    S_VINIT = 11'b00010000000,
    S_VDIV = 11'b00100000000,
    S_ROOT = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

endpackage

`default_nettype wire

/* hdl/rvsd_in_if.sv */
// Request channel: operation and sample with a valid/ready handshake.
`default_nettype none

interface rvsd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  operation;
  logic signed [rvsd_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

`default_nettype wire

/* hdl/rvsd_out_if.sv */
// Result channel: count, mean, variance and standard deviation.
`default_nettype none

interface rvsd_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [rvsd_pkg::OUT_COUNT_W-1:0]       count;
  logic signed [rvsd_pkg::MEAN_W-1:0]     mean;
  logic [rvsd_pkg::VAR_W-1:0]             variance;
  logic [rvsd_pkg::ROOT_W-1:0]            std_dev;

  modport source (output valid, output count, output mean, output variance, output std_dev,
                  input ready);
  modport sink   (input valid, input count, input mean, input variance, input std_dev,
                  output ready);
endinterface

`default_nettype wire

/* hdl/running_variance_stddev_unit.sv */
// A push after the first goes from acceptance through S_DIFF, 33 mean-divide steps,
// S_MEAN, S_ERR, S_MUL, S_ACC, S_VINIT, 64 variance-divide steps and 24 root steps,
// with all divide and root steps on one shared compare/subtract unit. A clear, or a push
// that leaves the count at one, goes from acceptance through S_VINIT to S_OUT.
// Throughput: one request at a time; the next is taken the cycle after the result leaves.
// Reset (synchronous, rst high) zeroes count, mean and sum and returns to idle.
`default_nettype none

module running_variance_stddev_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  rvsd_in_if.sink     req,
  rvsd_out_if.source  rsp
);

  localparam int D_W   = rvsd_pkg::D_W;
  localparam int X_W   = rvsd_pkg::X_W;
  localparam int SUB_W = rvsd_pkg::SUB_W;
  localparam int SUM_W = rvsd_pkg::SUM_W;
  localparam int VAR_W = rvsd_pkg::VAR_W;
  localparam int ROOT_W = rvsd_pkg::ROOT_W;
  localparam int CB    = rvsd_pkg::COUNT_BITS;

  rvsd_pkg::state_t state;

  logic [CB-1:0]                  count;
  logic signed [rvsd_pkg::MEAN_W-1:0] mean;
  logic [SUM_W-1:0]               sum;

  logic signed [X_W-1:0]          x;
  logic                           dneg, dzero, eneg, ezero;
  logic [31:0]                    dmag, emag;
  logic [VAR_W-1:0]               prod;
  logic [SUM_W-1:0]               dvd;
  logic [SUB_W-1:0]               rem;
  logic [CB-1:0]                  divisor;
  logic [rvsd_pkg::ITER_W-1:0]    iter;
  logic [VAR_W-1:0]               var_q;
  logic [ROOT_W-1:0]              root;

  // shared compare/subtract unit
  logic [SUB_W-1:0] opa, opb;
  logic [SUB_W:0]   diff;
  logic             ge;

  always_comb begin
    case (state)
      rvsd_pkg::S_MDIV, rvsd_pkg::S_VDIV: begin
        opa = {rem[SUB_W-2:0], dvd[SUM_W-1]};
        opb = SUB_W'(divisor);
      end
      rvsd_pkg::S_ROOT: begin
        opa = {rem[SUB_W-3:0], dvd[SUM_W-1 -: 2]};
        opb = SUB_W'({root, 2'b01});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = !diff[SUB_W];
  end

  function automatic logic [31:0] sat_mean(input logic [D_W:0] v);
    logic hi_ones, hi_zeros;
    hi_ones  = &v[D_W:31];
    hi_zeros = ~|v[D_W:31];
    if (hi_ones || hi_zeros) return v[31:0];
    return v[D_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [31:0] clamp_mag(input logic [D_W-1:0] m);
    return (|m[D_W-1:32]) ? 32'hFFFF_FFFF : m[31:0];
  endfunction

  // sign-extended operands for the wide adds
  logic signed [D_W:0] x_ext, mean_ext, in_x_ext;
  logic [D_W:0]        pos_diff, neg_diff;
  logic [D_W:0]        q_ext, mean_plus, mean_minus;
  logic [CB-1:0]       count_inc;
  logic [SUM_W:0]      sum_add;
  logic [31:0]         count_wide;

  always_comb begin
    x_ext     = {{(D_W + 1 - X_W){x[X_W-1]}}, x};
    mean_ext  = {{(D_W + 1 - 32){mean[31]}}, mean};
    in_x_ext  = {{(D_W + 1 - X_W){req.sample[rvsd_pkg::SAMPLE_BITS-1]}}, req.sample,
                 {rvsd_pkg::FRAC_W{1'b0}}};
    pos_diff  = x_ext - mean_ext;
    neg_diff  = mean_ext - x_ext;
    q_ext     = {1'b0, dvd[D_W-1:0]};
    mean_plus  = mean_ext + q_ext;
    mean_minus = mean_ext - q_ext;
    count_inc = (count != rvsd_pkg::COUNT_MAX) ? count + 1'b1 : count;
    sum_add   = {1'b0, sum} + {{(SUM_W + 1 - VAR_W){1'b0}}, prod};
    count_wide = 32'(count);
  end

  assign req.ready = (state == rvsd_pkg::S_IDLE);
  assign rsp.valid = (state == rvsd_pkg::S_OUT);
  assign rsp.count = (count_wide > 32'h0000_FFFF) ? 16'hFFFF : count_wide[15:0];
  assign rsp.mean  = mean;
  assign rsp.variance = var_q;
  assign rsp.std_dev  = root;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rvsd_pkg::S_IDLE;
      count <= '0;
      mean  <= '0;
      sum   <= '0;
    end else begin
      case (state)
        rvsd_pkg::S_IDLE: begin
          if (req.valid) begin
            if (req.operation == rvsd_pkg::OP_CLEAR) begin
              count <= '0;
              state <= rvsd_pkg::S_VINIT;
            end else begin
              count <= count_inc;
              x     <= X_W'(req.sample) <<< rvsd_pkg::FRAC_W;
              if (count == '0) begin
                mean  <= sat_mean(in_x_ext);
                sum   <= '0;
                state <= rvsd_pkg::S_VINIT;
              end else begin
                divisor <= count_inc;
                state   <= rvsd_pkg::S_DIFF;
              end
            end
          end
        end
        rvsd_pkg::S_DIFF: begin
          // magnitude of sample minus mean, left-aligned for the divider
          dneg  <= (x_ext < mean_ext);
          dzero <= (x_ext == mean_ext);
          dmag  <= clamp_mag((x_ext < mean_ext) ? neg_diff[D_W-1:0] : pos_diff[D_W-1:0]);
          dvd   <= {((x_ext < mean_ext) ? neg_diff[D_W-1:0] : pos_diff[D_W-1:0]),
                    {(SUM_W - D_W){1'b0}}};
          rem   <= '0;
          iter  <= rvsd_pkg::ITER_W'(D_W);
          state <= rvsd_pkg::S_MDIV;
        end
        rvsd_pkg::S_MDIV, rvsd_pkg::S_VDIV: begin
          if (iter == rvsd_pkg::ITER_W'(1) && state == rvsd_pkg::S_VDIV) begin
            // saturate the quotient, then load it for the root pass
            if (|dvd[SUM_W-2:VAR_W-1]) begin
              var_q <= {VAR_W{1'b1}};
              dvd   <= {{VAR_W{1'b1}}, {(SUM_W - VAR_W){1'b0}}};
            end else begin
              var_q <= {dvd[VAR_W-2:0], ge};
              dvd   <= {dvd[VAR_W-2:0], ge, {(SUM_W - VAR_W){1'b0}}};
            end
            rem   <= '0;
            root  <= '0;
            iter  <= rvsd_pkg::ITER_W'(ROOT_W);
            state <= rvsd_pkg::S_ROOT;
          end else begin
            rem  <= ge ? diff[SUB_W-1:0] : opa;
            dvd  <= {dvd[SUM_W-2:0], ge};
            iter <= iter - 1'b1;
            if (iter == rvsd_pkg::ITER_W'(1)) state <= rvsd_pkg::S_MEAN;
          end
        end
        rvsd_pkg::S_MEAN: begin
          mean  <= sat_mean(dneg ? mean_minus : mean_plus);
          state <= rvsd_pkg::S_ERR;
        end
        rvsd_pkg::S_ERR: begin
          eneg  <= (x_ext < mean_ext);
          ezero <= (x_ext == mean_ext);
          emag  <= clamp_mag((x_ext < mean_ext) ? neg_diff[D_W-1:0] : pos_diff[D_W-1:0]);
          state <= rvsd_pkg::S_MUL;
        end
        rvsd_pkg::S_MUL: begin
          prod  <= VAR_W'((64'(dmag) * 64'(emag)) >> rvsd_pkg::FRAC_W);
          state <= rvsd_pkg::S_ACC;
        end
        rvsd_pkg::S_ACC: begin
          if ((dneg != eneg) && !dzero && !ezero) begin
            sum <= (sum < SUM_W'(prod)) ? '0 : sum - SUM_W'(prod);
          end else begin
            sum <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
          end
          state <= rvsd_pkg::S_VINIT;
        end
        rvsd_pkg::S_VINIT: begin
          if (count > CB'(1)) begin
            dvd     <= sum;
            rem     <= '0;
            divisor <= count - 1'b1;
            iter    <= rvsd_pkg::ITER_W'(SUM_W);
            state   <= rvsd_pkg::S_VDIV;
          end else begin
            var_q <= '0;
            root  <= '0;
            state <= rvsd_pkg::S_OUT;
          end
        end
        rvsd_pkg::S_ROOT: begin
          // one result bit per step: trial is root with 01 appended
          rem  <= ge ? diff[SUB_W-1:0] : opa;
          root <= {root[ROOT_W-2:0], ge};
          dvd  <= {dvd[SUM_W-3:0], 2'b00};
          iter <= iter - 1'b1;
          if (iter == rvsd_pkg::ITER_W'(1)) state <= rvsd_pkg::S_OUT;
        end
        rvsd_pkg::S_OUT: begin
          if (rsp.ready) state <= rvsd_pkg::S_IDLE;
        end
        default: state <= rvsd_pkg::S_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("result shown while a new request can be taken");

  a_low_count_zero_var: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.count <= 16'd1) |-> (rsp.variance == '0 && rsp.std_dev == '0))
    else $error("nonzero variance with count at most one");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((VAR_W'(rsp.std_dev) * VAR_W'(rsp.std_dev)) <= rsp.variance))
    else $error("root squared exceeds variance");

  a_iter_live: assert property (@(posedge clk) disable iff (rst)
    (state == rvsd_pkg::S_MDIV || state == rvsd_pkg::S_VDIV || state == rvsd_pkg::S_ROOT)
      |-> iter != '0)
    else $error("iteration counter ran out inside a step loop");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == rvsd_pkg::S_MDIV || state == rvsd_pkg::S_VDIV) |-> divisor != '0)
    else $error("divide by zero in shared unit");

endmodule

`default_nettype wire
